/* rtl/adh_pkg.sv */
// ----------------------------------------------------------------------------
// adh_pkg
// Shared constants, types and threshold table for the angle deviation
// histogram: field widths, controller states, command and status groups.
// ----------------------------------------------------------------------------
package adh_pkg;

    localparam int COMPONENT_WIDTH     = 16;
    localparam int FIELD_WIDTH         = 16;
    localparam int COUNT_WIDTH         = 32;
    localparam int THRESHOLD_FRAC_BITS = 48;

    localparam int NUM_AXES    = 3;
    localparam int NUM_EDGES   = 12;
    localparam int NUM_BINS    = NUM_EDGES + 1;
    localparam int BIN_W       = 4;
    localparam int LIMIT_W     = 4;
    localparam int BIN_COUNT_W = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(5);

    localparam int NORM_W    = 2 * COMPONENT_WIDTH;
    localparam int DOT_W     = NORM_W + 1;
    localparam int PROD_W    = 2 * NORM_W;
    localparam int QUOT_W    = THRESHOLD_FRAC_BITS + 1;
    localparam int DIV_STEPS = QUOT_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int AXIS_W    = $clog2(NUM_AXES);

    localparam int IN_FIELDS_W  = 2 * NUM_AXES * FIELD_WIDTH;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = BIN_W + 1 + BIN_COUNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // bin edges in millidegrees
    localparam int EDGE_MDEG [NUM_EDGES] = '{
        1, 2, 5, 10, 20, 50, 100, 200, 500, 1000, 2000, 5000
    };
    // (2n+1)(2n+2) for the sine series terms
    localparam int SERIES_DIV [6] = '{12, 30, 56, 90, 132, 182};
    // pi/180 in Q0.64
    localparam logic [63:0] DEG_RAD_Q64 = 64'd321956420358983237;

    typedef logic [NUM_EDGES-1:0][THRESHOLD_FRAC_BITS-1:0] thresh_tab_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_SQ_DOT,
        ST_SQ_NORM,
        ST_DIVIDE,
        ST_UPDATE
    } adh_state_t;

    typedef struct packed {
        logic              capture;
        logic              acc;
        logic [AXIS_W-1:0] axis;
        logic              sq_dot;
        logic              sq_norm;
        logic              div_load;
        logic              div_step;
        logic              div_first;
        logic              update;
    } adh_cmd_t;

    typedef struct packed {
        logic degenerate;
        logic out_free;
    } adh_status_t;

    typedef struct packed {
        logic [BIN_W-1:0]       bin_index;
        logic                   angle_ok;
        logic                   degenerate;
        logic [BIN_COUNT_W-1:0] bin_count;
    } adh_result_t;

    function automatic logic signed [COMPONENT_WIDTH-1:0] to_component(
        input logic [FIELD_WIDTH-1:0] f
    );
        return COMPONENT_WIDTH'(f);
    endfunction

    function automatic logic [63:0] mul_hi64(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return p[127:64];
    endfunction

    // sin^2 of one bin edge, Q0.THRESHOLD_FRAC_BITS
    function automatic logic [63:0] edge_threshold(input int k);
        logic [63:0] e;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] t;
        logic [63:0] sum;
        e = 64'(EDGE_MDEG[k]);
        q = DEG_RAD_Q64 / 1000;
        r = DEG_RAD_Q64 % 1000;
        x = e * q + (e * r + 64'd500) / 1000;
        y = mul_hi64(x, x);
        t = y;
        sum = y;
        for (int n = 1; n <= 6; n++)
        begin
            t = mul_hi64(t, y);
            t = (t * 64'd4) / 64'(SERIES_DIV[n-1]);
            if ((n & 1) != 0)
            begin
                sum = sum - t;
            end
            else
            begin
                sum = sum + t;
            end
        end
        sum = sum + (64'd1 << (63 - THRESHOLD_FRAC_BITS));
        return sum >> (64 - THRESHOLD_FRAC_BITS);
    endfunction

    function automatic thresh_tab_t threshold_table();
        thresh_tab_t tab;
        for (int k = 0; k < NUM_EDGES; k++)
        begin
            tab[k] = THRESHOLD_FRAC_BITS'(edge_threshold(k));
        end
        return tab;
    endfunction

    localparam thresh_tab_t THRESHOLDS = threshold_table();

endpackage

/* rtl/adh_counters.sv */
// ----------------------------------------------------------------------------
// adh_counters
// Bank of saturating bin counters, cleared at reset, with the value after
// increment of the selected bin.
// ----------------------------------------------------------------------------
module adh_counters
    import adh_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   inc,
    input  logic [BIN_W-1:0]       bin_sel,
    output logic [COUNT_WIDTH-1:0] count_after
);

    logic [COUNT_WIDTH-1:0] counters_reg [NUM_BINS];
    logic [COUNT_WIDTH-1:0] count_cur;
    logic [COUNT_WIDTH-1:0] count_next;

    assign count_cur   = counters_reg[bin_sel];
    // saturate at full scale
    assign count_next  = (count_cur == '1) ? count_cur : count_cur + COUNT_WIDTH'(1);
    assign count_after = count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BINS; i++)
            begin
                counters_reg[i] <= '0;
            end
        end
        else if (inc)
        begin
            counters_reg[bin_sel] <= count_next;
        end
    end

endmodule

/* rtl/adh_datapath.sv */
// ----------------------------------------------------------------------------
// adh_datapath
// Norm and dot accumulation, shared squaring multiplier, radix-2 divider
// for sin^2 of the deviation, bin selection and the counter bank.
// ----------------------------------------------------------------------------
module adh_datapath
    import adh_pkg::*;
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  adh_cmd_t                            cmd,
    input  logic [NUM_AXES-1:0][FIELD_WIDTH-1:0] sight,
    input  logic [NUM_AXES-1:0][FIELD_WIDTH-1:0] tangent,
    input  logic [LIMIT_W-1:0]                  ok_bin_limit,
    output logic                                degenerate,
    output adh_result_t                         result
);

    logic signed [COMPONENT_WIDTH-1:0] sight_reg   [NUM_AXES];
    logic signed [COMPONENT_WIDTH-1:0] tangent_reg [NUM_AXES];
    logic        [NORM_W-1:0]          na_reg;
    logic        [NORM_W-1:0]          nb_reg;
    logic signed [DOT_W-1:0]           dot_reg;
    logic        [PROD_W-1:0]          dsq_reg;
    logic        [PROD_W-1:0]          nab_reg;
    logic        [PROD_W-1:0]          rem_reg;
    logic        [QUOT_W-1:0]          quot_reg;

    logic signed [COMPONENT_WIDTH-1:0] a_sel;
    logic signed [COMPONENT_WIDTH-1:0] b_sel;
    logic signed [NORM_W-1:0]          prod_aa;
    logic signed [NORM_W-1:0]          prod_bb;
    logic signed [NORM_W-1:0]          prod_ab;
    logic        [DOT_W-1:0]           dot_neg;
    logic        [NORM_W-1:0]          dmag;
    logic        [NORM_W-1:0]          mul_a;
    logic        [NORM_W-1:0]          mul_b;
    logic        [PROD_W-1:0]          mul_p;
    logic        [PROD_W:0]            trial;
    logic        [PROD_W:0]            diff;
    logic                              fits;
    logic        [QUOT_W-1:0]          quot_ceil;
    logic        [BIN_W-1:0]           bin_sel;
    logic        [COUNT_WIDTH-1:0]     count_after;

    // component products for the current axis
    assign a_sel   = sight_reg[cmd.axis];
    assign b_sel   = tangent_reg[cmd.axis];
    assign prod_aa = NORM_W'(a_sel) * NORM_W'(a_sel);
    assign prod_bb = NORM_W'(b_sel) * NORM_W'(b_sel);
    assign prod_ab = NORM_W'(a_sel) * NORM_W'(b_sel);

    assign dot_neg = -dot_reg;
    assign dmag    = dot_reg[DOT_W-1] ? NORM_W'(dot_neg) : NORM_W'(dot_reg);

    // shared multiplier: dot^2, then |a|^2 * |b|^2
    assign mul_a = cmd.sq_norm ? na_reg : dmag;
    assign mul_b = cmd.sq_norm ? nb_reg : dmag;
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // restoring divider step, no shift on the integer bit
    assign trial = cmd.div_first ? {1'b0, rem_reg} : {rem_reg, 1'b0};
    assign fits  = (trial >= {1'b0, nab_reg});
    assign diff  = trial - {1'b0, nab_reg};

    assign degenerate = (na_reg == '0) || (nb_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                sight_reg[i]   <= to_component(sight[i]);
                tangent_reg[i] <= to_component(tangent[i]);
            end
            na_reg  <= '0;
            nb_reg  <= '0;
            dot_reg <= '0;
        end
        else if (cmd.acc)
        begin
            na_reg  <= na_reg + NORM_W'($unsigned(prod_aa));
            nb_reg  <= nb_reg + NORM_W'($unsigned(prod_bb));
            dot_reg <= dot_reg + DOT_W'(prod_ab);
        end

        if (cmd.sq_dot)
        begin
            dsq_reg <= mul_p;
        end
        if (cmd.sq_norm)
        begin
            nab_reg <= mul_p;
        end

        if (cmd.div_load)
        begin
            rem_reg <= dsq_reg;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= fits ? PROD_W'(diff) : PROD_W'(trial);
            quot_reg <= {quot_reg[QUOT_W-2:0], fits};
        end
    end

    // ceiling of the quotient against each edge threshold
    always_comb
    begin
        quot_ceil = quot_reg + QUOT_W'(rem_reg != '0);
        bin_sel   = BIN_W'(NUM_EDGES);
        for (int k = NUM_EDGES - 1; k >= 0; k--)
        begin
            if (quot_ceil <= QUOT_W'(THRESHOLDS[k]))
            begin
                bin_sel = BIN_W'(k);
            end
        end
    end

    adh_counters u_counters (
        .clk         (clk),
        .rst_n       (rst_n),
        .inc         (cmd.update && !degenerate),
        .bin_sel     (bin_sel),
        .count_after (count_after)
    );

    always_comb
    begin
        result.degenerate = degenerate;
        if (degenerate)
        begin
            result.bin_index = '0;
            result.angle_ok  = 1'b0;
            result.bin_count = '0;
        end
        else
        begin
            result.bin_index = bin_sel;
            result.angle_ok  = (bin_sel < ok_bin_limit);
            result.bin_count = BIN_COUNT_W'(count_after);
        end
    end

endmodule

/* rtl/adh_ctrl.sv */
// ----------------------------------------------------------------------------
// adh_ctrl
// Sequencer for one transaction: norm accumulation over the axes, dot^2,
// norm product and divider iterations unless degenerate, histogram update.
// ----------------------------------------------------------------------------
module adh_ctrl
    import adh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  adh_status_t status,
    output adh_cmd_t    cmd
);

    adh_state_t        state_reg;
    adh_state_t        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    step_next   = '0;
                    state_next  = ST_NORM;
                end
            end
            ST_NORM:
            begin
                cmd.acc  = 1'b1;
                cmd.axis = step_reg[AXIS_W-1:0];
                if (step_reg == STEP_W'(NUM_AXES - 1))
                begin
                    step_next  = '0;
                    state_next = ST_SQ_DOT;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_SQ_DOT:
            begin
                cmd.sq_dot = 1'b1;
                if (status.degenerate)
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    state_next = ST_SQ_NORM;
                end
            end
            ST_SQ_NORM:
            begin
                cmd.sq_norm  = 1'b1;
                cmd.div_load = 1'b1;
                step_next    = '0;
                state_next   = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step  = 1'b1;
                cmd.div_first = (step_reg == '0);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = ST_UPDATE;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_UPDATE:
            begin
                if (status.out_free)
                begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/angle_deviation_histogram.sv */
// ----------------------------------------------------------------------------
// angle_deviation_histogram
// Histogram of the deviation from a right angle between a line-of-sight
// vector and a tangent-point vector, in thirteen saturating bins.
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one transaction per measurement: the sight and tangent
//   vectors, six signed components. m_axis returns one transaction per
//   input: bin index, ok flag and the bin's count after the increment, with
//   the degenerate flag on tuser (zero vector, nothing counted).
//   cfg_write_en writes the ok bin limit; write it only while idle.
//   the radix-2 divider that forms sin^2 of the deviation runs 49
//   iterations per input, skipped for a degenerate input.
//   one input is worked on at a time; s_axis_tready is high while idle, and
//   the next input is taken while the previous result waits on m_axis.
//   if the receiver stalls, the finished result holds in the output register
//   and the block waits before its histogram update until the slot is free.
//   reset clears all bin counters and sets the ok bin limit to 5.
// ----------------------------------------------------------------------------
module angle_deviation_histogram
    import adh_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  logic [LIMIT_W-1:0]     cfg_write_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // sight_x, sight_y, sight_z, tangent_x, tangent_y, tangent_z
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // bin_index, angle_ok, bin_count, zero padding
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // degenerate
    output logic                   m_axis_tuser
);

    logic [LIMIT_W-1:0] limit_reg;
    logic               m_valid_reg;
    adh_result_t        result_reg;

    adh_cmd_t                             cmd;
    adh_status_t                          status;
    adh_result_t                          dp_result;
    logic                                 dp_degenerate;
    logic [NUM_AXES-1:0][FIELD_WIDTH-1:0] sight;
    logic [NUM_AXES-1:0][FIELD_WIDTH-1:0] tangent;

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            sight[i]   = s_axis_tdata[i*FIELD_WIDTH +: FIELD_WIDTH];
            tangent[i] = s_axis_tdata[(NUM_AXES+i)*FIELD_WIDTH +: FIELD_WIDTH];
        end
    end

    assign status.degenerate = dp_degenerate;
    assign status.out_free   = !m_valid_reg || m_axis_tready;

    adh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    adh_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sight        (sight),
        .tangent      (tangent),
        .ok_bin_limit (limit_reg),
        .degenerate   (dp_degenerate),
        .result       (dp_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_write_en)
        begin
            limit_reg <= cfg_write_data;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.update)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            result_reg <= dp_result;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({result_reg.bin_count,
                                         result_reg.angle_ok,
                                         result_reg.bin_index});
    assign m_axis_tuser  = result_reg.degenerate;

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the angle deviation histogram. A fixed set of
// vector pairs is sent first: zero vectors, full-scale components, right
// angles and a sweep of small deviations across every bin edge. Random
// pairs follow, mostly near-perpendicular with random content and some
// raw noise, in several phases with different ok bin limits. Each result
// is compared with a bit-exact prediction of the bin, the ok flag, the
// degenerate flag and the updated bin count.
// ----------------------------------------------------------------------------
module testbench;
    import adh_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int LONG_HOLD     = 400;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 190;
    localparam int DIRECTED_ROWS = 25;
    localparam int ROW_COLS      = 11;

    localparam logic [63:0] RAD_PER_DEG_Q64 = 64'd321956420358983237;
    localparam int EDGE_MILLIDEG [NUM_EDGES] = '{
        1, 2, 5, 10, 20, 50, 100, 200, 500, 1000, 2000, 5000
    };
    localparam logic [LIMIT_W-1:0] PHASE_LIMIT [PHASES] = '{
        4'd0, 4'd13, 4'd1, 4'd15, 4'd12, 4'd7, 4'd14, 4'd5
    };

    typedef enum int {
        ROW_PREDICT,
        ROW_TYPED
    } row_mode_t;

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] tangent_z;
        logic signed [FIELD_WIDTH-1:0] tangent_y;
        logic signed [FIELD_WIDTH-1:0] tangent_x;
        logic signed [FIELD_WIDTH-1:0] sight_z;
        logic signed [FIELD_WIDTH-1:0] sight_y;
        logic signed [FIELD_WIDTH-1:0] sight_x;
    } vec_pair_t;

    typedef struct packed {
        logic [OUT_TDATA_W-OUT_FIELDS_W-1:0] pad;
        logic [BIN_COUNT_W-1:0]              bin_count;
        logic                                angle_ok;
        logic [BIN_W-1:0]                    bin_index;
    } result_word_t;

    // sight xyz, tangent xyz, mode, then bin, ok, degenerate, count
    int directed_stim [DIRECTED_ROWS][ROW_COLS] = '{
        '{1, 0, 0, 0, 1, 0, ROW_TYPED, 0, 1, 0, 1},
        '{0, 0, 0, 1, 2, 3, ROW_TYPED, 0, 0, 1, 0},
        '{5, -3, 7, 0, 0, 0, ROW_TYPED, 0, 0, 1, 0},
        '{0, 0, 0, 0, 0, 0, ROW_TYPED, 0, 0, 1, 0},
        '{32767, 32767, 32767, 32767, 32767, 32767, ROW_TYPED, 12, 0, 0, 1},
        '{-32768, -32768, -32768, -32768, -32768, -32768, ROW_TYPED, 12, 0, 0, 2},
        '{-32768, 0, 0, 0, 32767, 0, ROW_TYPED, 0, 1, 0, 2},
        '{0, 0, -1, -1, 0, 0, ROW_TYPED, 0, 1, 0, 3},
        '{1, 0, 0, 1, 1, 0, ROW_TYPED, 12, 0, 0, 3},
        '{0, -32768, 0, 0, 0, -32768, ROW_TYPED, 0, 1, 0, 4},
        '{-32768, 32767, -32768, 32767, -32768, 32767, ROW_PREDICT, 0, 0, 0, 0},
        '{32767, 0, 0, 1, 32767, 0, ROW_PREDICT, 0, 0, 0, 0},
        '{32767, 0, 0, 2, 32767, 0, ROW_PREDICT, 0, 0, 0, 0},
        '{32767, 0, 0, 3, 32767, 0, ROW_PREDICT, 0, 0, 0, 0},
        '{32767, 0, 0, 5, 32767, 0, ROW_PREDICT, 0, 0, 0, 0},
        '{32767, 0, 0, 9, 32767, 0, ROW_PREDICT, 0, 0, 0, 0},
        '{32767, 0, 0, 20, 32767, 0, ROW_PREDICT, 0, 0, 0, 0},
        '{32767, 0, 0, 45, 32767, 0, ROW_PREDICT, 0, 0, 0, 0},
        '{32767, 0, 0, 100, 32767, 0, ROW_PREDICT, 0, 0, 0, 0},
        '{32767, 0, 0, 250, 32767, 0, ROW_PREDICT, 0, 0, 0, 0},
        '{32767, 0, 0, 500, 32767, 0, ROW_PREDICT, 0, 0, 0, 0},
        '{32767, 0, 0, 800, 32767, 0, ROW_PREDICT, 0, 0, 0, 0},
        '{32767, 0, 0, 1200, 32767, 0, ROW_PREDICT, 0, 0, 0, 0},
        '{32767, 0, 0, 2900, 32767, 0, ROW_PREDICT, 0, 0, 0, 0},
        '{0, 0, 32767, 32767, -32768, 6000, ROW_PREDICT, 0, 0, 0, 0}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write_en;
    logic [LIMIT_W-1:0]     cfg_write_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // sight_x, sight_y, sight_z, tangent_x, tangent_y, tangent_z
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // bin_index, angle_ok, bin_count, zero padding
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // degenerate
    logic                   m_axis_tuser;

    logic [THRESHOLD_FRAC_BITS-1:0] edge_sin_sq [NUM_EDGES];
    logic [BIN_COUNT_W-1:0]         bin_tally [NUM_BINS];
    logic [LIMIT_W-1:0]             ok_limit_model;
    adh_result_t                    pending_results [$];

    bit burst;
    bit long_hold_req;
    int mismatches;
    int results_seen;
    int quiet_cycles;

    angle_deviation_histogram dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // sin^2 of a bin edge by the truncated sine series, rounded to the threshold format
    function automatic logic [THRESHOLD_FRAC_BITS-1:0] sin_sq_edge(input int millideg);
        logic [127:0] wide;
        logic [63:0]  x;
        logic [63:0]  y;
        logic [63:0]  t;
        logic [63:0]  acc;
        int           n;
        wide = 128'(millideg) * 128'(RAD_PER_DEG_Q64) + 128'd500;
        x = 64'(wide / 128'd1000);
        wide = 128'(x) * 128'(x);
        y = wide[127:64];
        t = y;
        acc = y;
        for (n = 1; n <= 6; n++)
        begin
            wide = 128'(t) * 128'(y);
            t = wide[127:64];
            t = (t * 64'd4) / 64'((2 * n + 1) * (2 * n + 2));
            if ((n % 2) != 0)
            begin
                acc = acc - t;
            end
            else
            begin
                acc = acc + t;
            end
        end
        acc = acc + (64'd1 << (63 - THRESHOLD_FRAC_BITS));
        return THRESHOLD_FRAC_BITS'(acc >> (64 - THRESHOLD_FRAC_BITS));
    endfunction

    // bins the pair, bumps the saturating tally and returns the expected result
    function automatic adh_result_t classify_deviation(input vec_pair_t v);
        longint           ax;
        longint           ay;
        longint           az;
        longint           bx;
        longint           by;
        longint           bz;
        longint           na;
        longint           nb;
        longint           dot;
        logic [127:0]     lhs;
        logic [127:0]     nab;
        logic [BIN_W-1:0] bin;
        bit               found;
        int               k;
        adh_result_t      r;
        ax = longint'($signed(v.sight_x));
        ay = longint'($signed(v.sight_y));
        az = longint'($signed(v.sight_z));
        bx = longint'($signed(v.tangent_x));
        by = longint'($signed(v.tangent_y));
        bz = longint'($signed(v.tangent_z));
        na = ax * ax + ay * ay + az * az;
        nb = bx * bx + by * by + bz * bz;
        dot = ax * bx + ay * by + az * bz;
        r = '0;
        if (na == 0 || nb == 0)
        begin
            r.degenerate = 1'b1;
            return r;
        end
        if (dot < 0)
        begin
            dot = -dot;
        end
        lhs = (128'(dot) * 128'(dot)) << THRESHOLD_FRAC_BITS;
        nab = 128'(na) * 128'(nb);
        bin = BIN_W'(NUM_EDGES);
        found = 1'b0;
        for (k = 0; k < NUM_EDGES; k++)
        begin
            if (!found && lhs <= 128'(edge_sin_sq[k]) * nab)
            begin
                bin = BIN_W'(k);
                found = 1'b1;
            end
        end
        if (bin_tally[bin] != '1)
        begin
            bin_tally[bin] = bin_tally[bin] + 1'b1;
        end
        r.bin_index = bin;
        r.angle_ok = (bin < ok_limit_model);
        r.bin_count = bin_tally[bin];
        return r;
    endfunction

    function automatic logic signed [FIELD_WIDTH-1:0] clamp_component(input int v);
        if (v > 32767)
        begin
            return 16'sd32767;
        end
        if (v < -32768)
        begin
            return -16'sd32768;
        end
        return FIELD_WIDTH'(v);
    endfunction

    // near-perpendicular pairs with a random tilt, plus raw noise and zero vectors
    function automatic vec_pair_t make_random_pair();
        int        a [3];
        int        b [3];
        int        kind;
        int        sh;
        int        psh;
        int        i;
        bit        flip;
        vec_pair_t p;
        kind = $urandom_range(0, 99);
        p = {$urandom, $urandom, $urandom};
        if (kind < 20)
        begin
            return p;
        end
        if (kind < 26)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                {p.sight_x, p.sight_y, p.sight_z} = '0;
            end
            else
            begin
                {p.tangent_x, p.tangent_y, p.tangent_z} = '0;
            end
            return p;
        end
        sh = $urandom_range(0, 14);
        for (i = 0; i < 3; i++)
        begin
            a[i] = int'($signed(16'($urandom))) >>> sh;
        end
        case ($urandom_range(0, 2))
            0: b = '{-a[1], a[0], 0};
            1: b = '{0, -a[2], a[1]};
            default: b = '{a[2], 0, -a[0]};
        endcase
        psh = $urandom_range(0, 16);
        flip = $urandom_range(0, 1);
        for (i = 0; i < 3; i++)
        begin
            if (psh < 16)
            begin
                b[i] = b[i] + (int'($signed(16'($urandom))) >>> psh);
            end
            if (flip)
            begin
                b[i] = -b[i];
            end
        end
        if ($urandom_range(0, 1) == 1)
        begin
            p = {clamp_component(a[2]), clamp_component(a[1]), clamp_component(a[0]),
                 clamp_component(b[2]), clamp_component(b[1]), clamp_component(b[0])};
        end
        else
        begin
            p = {clamp_component(b[2]), clamp_component(b[1]), clamp_component(b[0]),
                 clamp_component(a[2]), clamp_component(a[1]), clamp_component(a[0])};
        end
        return p;
    endfunction

    task automatic report_mismatch(input string what, input longint got_v, input longint want_v);
        $display("result %0d: %s got %0d expected %0d", results_seen, what, got_v, want_v);
        mismatches++;
    endtask

    task automatic send_item(input vec_pair_t pair, input bit typed, input adh_result_t typed_want);
        int          gap;
        adh_result_t predicted;
        gap = burst ? 0 : $urandom_range(0, 5);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata <= pair;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        predicted = classify_deviation(pair);
        pending_results.push_back(typed ? typed_want : predicted);
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_ok_limit(input logic [LIMIT_W-1:0] value);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        ok_limit_model = value;
    endtask

    initial
    begin
        vec_pair_t   pair;
        adh_result_t want;
        int          row;
        int          ph;
        int          n;
        cfg_write_en = 1'b0;
        cfg_write_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        rst_n = 1'b0;
        burst = 1'b0;
        long_hold_req = 1'b0;
        mismatches = 0;
        results_seen = 0;
        ok_limit_model = 4'd5;
        for (n = 0; n < NUM_BINS; n++)
        begin
            bin_tally[n] = '0;
        end
        for (n = 0; n < NUM_EDGES; n++)
        begin
            edge_sin_sq[n] = sin_sq_edge(EDGE_MILLIDEG[n]);
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (row = 0; row < DIRECTED_ROWS; row++)
        begin
            pair.sight_x = FIELD_WIDTH'(directed_stim[row][0]);
            pair.sight_y = FIELD_WIDTH'(directed_stim[row][1]);
            pair.sight_z = FIELD_WIDTH'(directed_stim[row][2]);
            pair.tangent_x = FIELD_WIDTH'(directed_stim[row][3]);
            pair.tangent_y = FIELD_WIDTH'(directed_stim[row][4]);
            pair.tangent_z = FIELD_WIDTH'(directed_stim[row][5]);
            want.bin_index = BIN_W'(directed_stim[row][7]);
            want.angle_ok = directed_stim[row][8][0];
            want.degenerate = directed_stim[row][9][0];
            want.bin_count = BIN_COUNT_W'(directed_stim[row][10]);
            send_item(pair, directed_stim[row][6] == ROW_TYPED, want);
        end
        drain_results();

        for (ph = 0; ph < PHASES; ph++)
        begin
            write_ok_limit(PHASE_LIMIT[ph]);
            burst = (ph == 2 || ph == 5);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // receiver backs off long enough for the input side to stall
                if (ph == 3 && n == 20)
                begin
                    long_hold_req = 1'b1;
                end
                send_item(make_random_pair(), 1'b0, '0);
            end
            drain_results();
        end

        repeat (64) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial
    begin
        int           stall;
        result_word_t got;
        adh_result_t  want;
        forever
        begin
            @(negedge clk);
            stall = burst ? 0 : $urandom_range(0, 5);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall = LONG_HOLD;
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
            begin
                @(posedge clk);
            end
            got = m_axis_tdata;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with none pending, bin", got.bin_index, -1);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.bin_index != want.bin_index)
                begin
                    report_mismatch("bin_index", got.bin_index, want.bin_index);
                end
                if (got.angle_ok != want.angle_ok)
                begin
                    report_mismatch("angle_ok", got.angle_ok, want.angle_ok);
                end
                if (m_axis_tuser !== want.degenerate)
                begin
                    report_mismatch("degenerate", m_axis_tuser, want.degenerate);
                end
                if (got.bin_count != want.bin_count)
                begin
                    report_mismatch("bin_count", got.bin_count, want.bin_count);
                end
                if (got.pad != '0)
                begin
                    report_mismatch("padding", got.pad, 0);
                end
            end
        end
    end

    // cycles since the last transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule
